FILE: hdl/assert_macros.svh
// Assertion macros shared by the pattern scrubber RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that implies another one in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A condition that implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/pfsu_pkg.sv
// Package with the command codes and controller interface types of the pattern scrubber.
`timescale 1ns / 1ps
`default_nettype none

package pfsu_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_DUMP    = 2'd1,
		CMD_DRAIN   = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	// Shortest pattern in words that enables the search.
	localparam int unsigned MIN_WORDS = 4;

	// Word index of the pattern length register on the configuration port.
	localparam logic CFG_PATTERN_WORDS = 1'b0;

	typedef struct packed {
		logic take;
		logic pat_write;
		logic clear_scan;
		logic set_drained;
		logic emit_direct;
		logic rd_head;
		logic pop;
		logic push;
		logic cmp_start;
		logic cmp_run;
		logic set_match;
		logic res_load;
	} ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic fill_zero;
		logic fill_ge_len;
		logic cmp_needed;
		logic cmp_mismatch;
		logic cmp_equal_all;
		logic res_free;
	} stat_t;

endpackage

`default_nettype wire

FILE: hdl/pfsu_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pfsu_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  pfsu_pkg::stat_t st,
	output pfsu_pkg::ctrl_t ctl
);
	import pfsu_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_POP    = 6'b000100,
		S_CHECK  = 6'b001000,
		S_CMP    = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		ctl = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.take = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.cmd)
					CMD_LOAD: begin
						ctl.pat_write = 1'b1;
						state_d = S_FINISH;
					end
					CMD_DUMP: begin
						if (st.fill_ge_len && st.fill_zero) begin
							ctl.emit_direct = 1'b1;
							state_d = S_FINISH;
						end else if (st.fill_ge_len) begin
							ctl.rd_head = 1'b1;
							state_d = S_POP;
						end else begin
							ctl.push = 1'b1;
							state_d = S_CHECK;
						end
					end
					CMD_DRAIN: begin
						if (st.fill_zero) begin
							ctl.set_drained = 1'b1;
							state_d = S_FINISH;
						end else begin
							ctl.rd_head = 1'b1;
							state_d = S_POP;
						end
					end
					CMD_RESTART: begin
						ctl.clear_scan = 1'b1;
						state_d = S_FINISH;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_POP: begin
				ctl.pop = 1'b1;
				if (st.cmd == CMD_DUMP) begin
					ctl.push = 1'b1;
					state_d = S_CHECK;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_CHECK: begin
				if (st.cmp_needed) begin
					ctl.cmp_start = 1'b1;
					state_d = S_CMP;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_CMP: begin
				ctl.cmp_run = 1'b1;
				if (st.cmp_mismatch) begin
					state_d = S_FINISH;
				end else if (st.cmp_equal_all) begin
					ctl.set_match = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (st.res_free) begin
					ctl.res_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_NEXT(a_take_decodes, clk, arst_n, ctl.take, state_q == S_DECODE, "Accepted transaction was not decoded.")
	`ASSERT_NEXT(a_mismatch_ends, clk, arst_n, state_q == S_CMP && st.cmp_mismatch, state_q == S_FINISH, "Compare did not stop at a mismatch.")
	`ASSERT_IMPLIES(a_match_once, clk, arst_n, ctl.set_match, st.cmp_equal_all && !st.cmp_mismatch, "Match recorded without a full compare.")

endmodule

`default_nettype wire

FILE: hdl/pfsu_datapath.sv
// Datapath with the pattern store, the byte window, the byte-serial compare and the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pfsu_datapath #(
	parameter int unsigned MAX_PATTERN_WORDS = 64,
	parameter int unsigned WORD_BYTES        = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  pfsu_pkg::ctrl_t  ctl,
	output pfsu_pkg::stat_t  st,
	input  wire  [6:0]       pattern_words,
	input  wire  [1:0]       command,
	input  wire  [63:0]      pattern_word,
	input  wire  [7:0]       dump_byte,
	output logic             res_valid,
	input  wire              res_ready,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             found,
	output logic [31:0]      match_offset,
	output logic             drained
);
	import pfsu_pkg::*;

	localparam int unsigned WB_BITS = WORD_BYTES * 8;
	localparam int unsigned WIN_MAX = MAX_PATTERN_WORDS * WORD_BYTES;
	localparam int unsigned WA_W    = $clog2(WIN_MAX);
	localparam int unsigned LEN_W   = $clog2(WIN_MAX + 1);
	localparam int unsigned PA_W    = $clog2(MAX_PATTERN_WORDS);
	localparam int unsigned LI_W    = $clog2(MAX_PATTERN_WORDS + 1);
	localparam int unsigned BS_W    = $clog2(WORD_BYTES);

	logic [WB_BITS-1:0] pat_mem [MAX_PATTERN_WORDS];
	logic [7:0]         win_mem [WIN_MAX];

	cmd_t               cmd_q;
	logic [WB_BITS-1:0] word_q;
	logic [7:0]         byte_q;

	logic [LI_W-1:0]    load_idx_q;
	logic [WA_W-1:0]    head_q;
	logic [LEN_W-1:0]   fill_q;
	logic [31:0]        offset_q;
	logic               match_q;
	logic [31:0]        first_q;
	logic [LEN_W-1:0]   scrub_q;
	logic               ov_q;
	logic [7:0]         ob_q;
	logic               dr_q;

	logic [LEN_W-1:0]   idx_q;
	logic [WA_W-1:0]    caddr_q;
	logic [PA_W-1:0]    pw_q;
	logic [BS_W-1:0]    pb_q;
	logic [BS_W-1:0]    pb_s1;
	logic               cmp_v_s1;
	logic               cmp_last_s1;
	logic [7:0]         win_rdata_q;
	logic [WB_BITS-1:0] pat_rdata_q;

	logic               res_valid_q;
	logic               res_ov_q;
	logic [7:0]         res_ob_q;
	logic               res_found_q;
	logic [31:0]        res_off_q;
	logic               res_dr_q;

	logic [7:0]         words8;
	logic [LEN_W-1:0]   len_c;
	logic [WA_W:0]      tail_sum;
	logic [WA_W-1:0]    tail;
	logic [WA_W-1:0]    head_inc;
	logic [WA_W-1:0]    caddr_inc;
	logic [LEN_W-1:0]   idx_next;
	logic               issue;
	logic               win_rd_en;
	logic [WA_W-1:0]    win_raddr;
	logic [7:0]         pat_byte;
	logic               bytes_equal;

	always_comb begin
		words8 = {1'b0, pattern_words};
		if (words8 > 8'(MAX_PATTERN_WORDS)) begin
			words8 = 8'(MAX_PATTERN_WORDS);
		end
		if (words8 < 8'(MIN_WORDS)) begin
			len_c = '0;
		end else begin
			len_c = LEN_W'(words8) * LEN_W'(WORD_BYTES);
		end
	end

	assign tail_sum = {1'b0, head_q} + (WA_W + 1)'(fill_q);
	assign tail = (tail_sum >= (WA_W + 1)'(WIN_MAX)) ?
		WA_W'(tail_sum - (WA_W + 1)'(WIN_MAX)) : WA_W'(tail_sum);
	assign head_inc = (head_q == WA_W'(WIN_MAX - 1)) ? '0 : head_q + WA_W'(1);
	assign caddr_inc = (caddr_q == WA_W'(WIN_MAX - 1)) ? '0 : caddr_q + WA_W'(1);
	assign idx_next = idx_q + LEN_W'(1);
	assign issue = ctl.cmp_run && (idx_q < len_c);
	assign win_rd_en = ctl.rd_head || issue;
	assign win_raddr = ctl.rd_head ? head_q : caddr_q;
	assign pat_byte = pat_rdata_q[{pb_s1, 3'b000} +: 8];
	assign bytes_equal = (pat_byte == win_rdata_q);

	always_comb begin
		st.cmd = cmd_q;
		st.fill_zero = (fill_q == '0);
		st.fill_ge_len = (fill_q >= len_c);
		st.cmp_needed = !match_q && (len_c != '0) && (fill_q == len_c);
		st.cmp_mismatch = cmp_v_s1 && !bytes_equal;
		st.cmp_equal_all = cmp_v_s1 && cmp_last_s1 && bytes_equal;
		st.res_free = !res_valid_q || res_ready;
	end

	always_ff @(posedge clk) begin
		if (ctl.pat_write && (load_idx_q < LI_W'(MAX_PATTERN_WORDS))) begin
			pat_mem[load_idx_q[PA_W-1:0]] <= word_q;
		end
		pat_rdata_q <= pat_mem[pw_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			win_mem[tail] <= byte_q;
		end
		if (win_rd_en) begin
			win_rdata_q <= win_mem[win_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			cmd_q  <= cmd_t'(command);
			word_q <= pattern_word[WB_BITS-1:0];
			byte_q <= dump_byte;
			ob_q   <= '0;
		end else if (ctl.pop) begin
			ob_q <= (scrub_q != '0) ? 8'd0 : win_rdata_q;
		end else if (ctl.emit_direct) begin
			ob_q <= byte_q;
		end
		if (ctl.cmp_start) begin
			idx_q   <= '0;
			caddr_q <= head_q;
			pw_q    <= '0;
			pb_q    <= '0;
		end else if (issue) begin
			idx_q   <= idx_next;
			caddr_q <= caddr_inc;
			if (pb_q == BS_W'(WORD_BYTES - 1)) begin
				pb_q <= '0;
				pw_q <= pw_q + PA_W'(1);
			end else begin
				pb_q <= pb_q + BS_W'(1);
			end
		end
		pb_s1 <= pb_q;
		cmp_last_s1 <= (idx_next == len_c);
		if (ctl.res_load) begin
			res_ov_q    <= ov_q;
			res_ob_q    <= ob_q;
			res_found_q <= match_q;
			res_off_q   <= first_q;
			res_dr_q    <= dr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx_q  <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			offset_q    <= '0;
			match_q     <= 1'b0;
			first_q     <= '0;
			scrub_q     <= '0;
			ov_q        <= 1'b0;
			dr_q        <= 1'b0;
			cmp_v_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.clear_scan) begin
				load_idx_q <= '0;
				head_q     <= '0;
				fill_q     <= '0;
				offset_q   <= '0;
				match_q    <= 1'b0;
				first_q    <= '0;
				scrub_q    <= '0;
			end else begin
				if (ctl.pat_write && (load_idx_q < LI_W'(MAX_PATTERN_WORDS))) begin
					load_idx_q <= load_idx_q + LI_W'(1);
				end
				if (ctl.pop) begin
					head_q <= head_inc;
				end
				if (ctl.push && !ctl.pop) begin
					fill_q <= fill_q + LEN_W'(1);
				end else if (ctl.pop && !ctl.push) begin
					fill_q <= fill_q - LEN_W'(1);
				end
				if ((ctl.pop || ctl.emit_direct) && (offset_q != 32'hFFFF_FFFF)) begin
					offset_q <= offset_q + 32'd1;
				end
				if (ctl.set_match) begin
					match_q <= 1'b1;
					first_q <= offset_q;
					scrub_q <= fill_q;
				end else if (ctl.pop && (scrub_q != '0)) begin
					scrub_q <= scrub_q - LEN_W'(1);
				end
			end
			if (ctl.take) begin
				ov_q <= 1'b0;
				dr_q <= 1'b0;
			end else begin
				if (ctl.pop || ctl.emit_direct) begin
					ov_q <= 1'b1;
				end
				if (ctl.set_drained) begin
					dr_q <= 1'b1;
				end
			end
			cmp_v_s1 <= issue;
			if (ctl.res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign out_valid    = res_ov_q;
	assign out_byte     = res_ob_q;
	assign found        = res_found_q;
	assign match_offset = res_off_q;
	assign drained      = res_dr_q;

	`ASSERT_ALWAYS(a_scrub_le_fill, clk, arst_n, scrub_q <= fill_q, "More scrubbed bytes than bytes in the window.")
	`ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= LEN_W'(WIN_MAX), "Window fill exceeds the window size.")
	`ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, ctl.res_load, !res_valid_q || res_ready, "Result overwritten before it was taken.")
	`ASSERT_IMPLIES(a_single_match, clk, arst_n, match_q, !ctl.cmp_start, "Compare started after the first match.")

endmodule

`default_nettype wire

FILE: hdl/pattern_find_and_scrub_unit.sv
// Top level of the pattern scrubber with the configuration register and the two sub-blocks.
`timescale 1ns / 1ps
`default_nettype none

// Loads a pattern of 64-bit words (command 0), then scrubs a byte stream (command 1): the
// stream passes through a delay window as long as the pattern, and the first window that
// equals the pattern bytes leaves as zeros, with its start offset reported. Command 2 drains
// one byte, command 3 restarts the scan. Every transaction gives one result. Until the first
// match, every dump that leaves the window at the pattern length runs a byte-serial compare
// through the single read port of the window memory. A transaction also waits at its end
// while the previous result has not been taken. The user must write the pattern length
// register at address 0 only while the block is idle; the block itself does not enforce it.
module pattern_find_and_scrub_unit #(
	parameter int unsigned MAX_PATTERN_WORDS = 64,
	parameter int unsigned WORD_BYTES        = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  command,
	input  wire  [63:0] pattern_word,
	input  wire  [7:0]  dump_byte,
	output logic        res_valid,
	input  wire         res_ready,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        found,
	output logic [31:0] match_offset,
	output logic        drained
);
	import pfsu_pkg::*;

	logic [6:0] pattern_words_q;
	ctrl_t      ctl;
	stat_t      st;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_words_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_PATTERN_WORDS)) begin
			pattern_words_q <= pwdata[6:0];
		end
	end

	always_comb begin
		if (psel && (paddr[2] == CFG_PATTERN_WORDS)) begin
			prdata = {25'd0, pattern_words_q};
		end else begin
			prdata = '0;
		end
	end

	pfsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.ctl      (ctl)
	);

	pfsu_datapath #(
		.MAX_PATTERN_WORDS (MAX_PATTERN_WORDS),
		.WORD_BYTES        (WORD_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.st            (st),
		.pattern_words (pattern_words_q),
		.command       (command),
		.pattern_word  (pattern_word),
		.dump_byte     (dump_byte),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.found         (found),
		.match_offset  (match_offset),
		.drained       (drained)
	);

endmodule

`default_nettype wire

FILE: dv/pattern_find_and_scrub_unit_tb.sv
// Testbench for the pattern scrubber: a directed table, then random scan phases checked by a predictor.
`timescale 1ns / 1ps

module pattern_find_and_scrub_unit_tb;
	import pfsu_pkg::*;

	localparam int unsigned MAX_WORDS    = 64;
	localparam int unsigned WORD_BYTES   = 8;
	localparam int unsigned ITEMS_TARGET = 1800;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned END_SLACK    = 600;
	localparam int unsigned LIMIT        = 4000000;
	localparam int          BIG_EP       = 3;
	localparam logic [2:0]  PW_ADDR      = {CFG_PATTERN_WORDS, 2'b00};

	typedef struct packed {
		logic        emit;
		logic [7:0]  data;
		logic        hit;
		logic [31:0] hit_ofs;
		logic        dry;
	} scrub_res_t;

	typedef struct {
		cmd_t        c;
		logic [63:0] w;
		logic [7:0]  b;
		bit          typed;
		scrub_res_t  r;
	} dir_row_t;

	typedef enum {RX_STREAM, RX_ALTERNATE, RX_BUSY, RX_CHOKED} rx_mode_t;

	localparam scrub_res_t NO_RES = '0;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [63:0] pattern_word;
	logic [7:0]  dump_byte;
	logic        res_valid;
	logic        res_ready;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        found;
	logic [31:0] match_offset;
	logic        drained;

	// Predictor state.
	logic [63:0] pat_mem [MAX_WORDS];
	int unsigned load_ptr;
	logic [7:0]  win_q [$];
	logic [31:0] stream_pos;
	logic        hit_seen;
	logic [31:0] hit_pos;
	logic [6:0]  words_cfg;

	scrub_res_t  pending_results [$];
	scrub_res_t  got_r;
	scrub_res_t  want_r;
	dir_row_t    dir_tab [$];

	int unsigned n_errors;
	int unsigned n_items;
	int unsigned n_results;
	int unsigned n_hits;
	int unsigned n_dry;
	int unsigned n_cfg;
	int unsigned n_eps;
	int unsigned burst_left;
	int unsigned cycle_cnt;
	bit          long_hold;
	rx_mode_t    rx_mode;
	int unsigned rx_left;
	int unsigned hold_cnt;

	pattern_find_and_scrub_unit #(
		.MAX_PATTERN_WORDS(MAX_WORDS),
		.WORD_BYTES(WORD_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.pattern_word(pattern_word),
		.dump_byte(dump_byte),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.found(found),
		.match_offset(match_offset),
		.drained(drained)
	);

	function automatic int unsigned window_len();
		int unsigned w;
		w = {25'd0, words_cfg};
		if (w > MAX_WORDS) w = MAX_WORDS;
		if (w < MIN_WORDS) return 0;
		return w * WORD_BYTES;
	endfunction

	function automatic logic [7:0] pattern_byte(int unsigned i);
		return pat_mem[i / WORD_BYTES][8 * (i % WORD_BYTES) +: 8];
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return '1;
			default: return rnd64();
		endcase
	endfunction

	function automatic dir_row_t dir_row(cmd_t c, logic [63:0] w, logic [7:0] b, bit typed,
		logic emit, logic [7:0] data, logic dry);
		dir_row_t t;
		t.c = c;
		t.w = w;
		t.b = b;
		t.typed = typed;
		t.r = '0;
		t.r.emit = emit;
		t.r.data = data;
		t.r.dry = dry;
		return t;
	endfunction

	task automatic advance_scrubber(input cmd_t c, input logic [63:0] w, input logic [7:0] b,
		output scrub_res_t r);
		int unsigned len;
		int unsigned k;
		bit same;
		len = window_len();
		r = '0;
		case (c)
			CMD_LOAD: begin
				if (load_ptr < MAX_WORDS) begin
					pat_mem[load_ptr] = w;
					load_ptr++;
				end
			end
			CMD_DUMP: begin
				if (win_q.size() >= len) begin
					r.emit = 1'b1;
					if (win_q.size() == 0) begin
						r.data = b;
					end else begin
						r.data = win_q.pop_front();
						win_q.push_back(b);
					end
					if (stream_pos != 32'hFFFF_FFFF) stream_pos++;
				end else begin
					win_q.push_back(b);
				end
				if (!hit_seen && len > 0 && win_q.size() == len) begin
					same = 1'b1;
					for (k = 0; k < len; k++)
						if (win_q[k] != pattern_byte(k)) same = 1'b0;
					if (same) begin
						for (k = 0; k < len; k++) win_q[k] = 8'h00;
						hit_seen = 1'b1;
						hit_pos = stream_pos;
						n_hits++;
					end
				end
			end
			CMD_DRAIN: begin
				if (win_q.size() > 0) begin
					r.emit = 1'b1;
					r.data = win_q.pop_front();
					if (stream_pos != 32'hFFFF_FFFF) stream_pos++;
				end else begin
					r.dry = 1'b1;
					n_dry++;
				end
			end
			default: begin
				win_q.delete();
				stream_pos = '0;
				hit_seen = 1'b0;
				hit_pos = '0;
				load_ptr = 0;
			end
		endcase
		r.hit = hit_seen;
		r.hit_ofs = hit_pos;
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("ERROR at %0t: %s is %0h, expected %0h", $realtime, what, got, want);
		n_errors++;
	endtask

	task automatic send_txn(input cmd_t c, input logic [63:0] w, input logic [7:0] b,
		input bit typed, input scrub_res_t typed_r);
		scrub_res_t r;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		command <= c;
		pattern_word <= w;
		dump_byte <= b;
		do @(posedge clk); while (!in_ready);
		advance_scrubber(c, w, b, r);
		pending_results.push_back(typed ? typed_r : r);
		n_items++;
	endtask

	task automatic dump(input logic [7:0] b);
		send_txn(CMD_DUMP, rnd64(), b, 1'b0, NO_RES);
	endtask

	task automatic drain();
		send_txn(CMD_DRAIN, rnd64(), 8'($urandom), 1'b0, NO_RES);
	endtask

	task automatic restart_scan();
		send_txn(CMD_RESTART, rnd64(), 8'($urandom), 1'b0, NO_RES);
	endtask

	task automatic load_word(input logic [63:0] w);
		send_txn(CMD_LOAD, w, 8'($urandom), 1'b0, NO_RES);
	endtask

	task automatic noise_step();
		case ($urandom_range(0, 19))
			0, 1: drain();
			2: load_word(pick_word());
			3: if ($urandom_range(0, 3) == 0) restart_scan();
			default: dump(8'($urandom));
		endcase
	endtask

	task automatic wait_idle(input int unsigned settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_words(input logic [6:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PW_ADDR;
		pwdata <= {25'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		words_cfg = v;
		n_cfg++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[6:0] !== v)
			flag_mismatch("pattern_words readback", 64'(prdata[6:0]), 64'(v));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic scrub_episode(input int ep);
		logic [6:0] wv;
		int unsigned len;
		int unsigned n;
		int unsigned k;
		int unsigned bad;
		int unsigned copies;
		wait_idle(8);
		case (ep)
			0: wv = 7'd4;
			2: wv = 7'd0;
			BIG_EP: wv = 7'(MAX_WORDS);
			4: wv = 7'd3;
			default: begin
				case ($urandom_range(0, 9))
					0: wv = 7'($urandom_range(0, 3));
					1: wv = 7'd8;
					2: wv = 7'($urandom_range(5, 12));
					default: wv = 7'($urandom_range(4, 5));
				endcase
			end
		endcase
		if (ep < 5 || $urandom_range(0, 3) != 0) write_words(wv);
		len = window_len();
		if (ep == BIG_EP) begin
			restart_scan();
			for (k = 0; k < len; k++) dump(pattern_byte(k));
			repeat (12) dump(8'($urandom));
			repeat (20) drain();
		end else begin
			if ($urandom_range(0, 3) != 0) begin
				restart_scan();
				if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 12)) load_word(pick_word());
			end
			if (ep == 1) long_hold = 1'b1;
			repeat ($urandom_range(0, len + 8)) noise_step();
			copies = (len > 0) ? $urandom_range(1, 3) : 0;
			repeat (copies) begin
				bad = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len - 1) : len;
				for (k = 0; k < len; k++)
					dump((k == bad) ? pattern_byte(k) ^ 8'($urandom_range(1, 255)) : pattern_byte(k));
				repeat ($urandom_range(0, 4)) noise_step();
			end
			repeat ($urandom_range(0, 10)) noise_step();
			n = (win_q.size() < 80) ? win_q.size() : 80;
			repeat (n + $urandom_range(0, 2)) drain();
		end
		n_eps++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Run stopped by the watchdog after %0d cycles", LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		res_ready = 1'b0;
		rx_left = 0;
		rx_mode = RX_STREAM;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				res_ready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
			end
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 160);
			end
			rx_left--;
			case (rx_mode)
				RX_STREAM: res_ready <= 1'b1;
				RX_ALTERNATE: res_ready <= ~res_ready;
				RX_BUSY: res_ready <= ($urandom_range(0, 9) < 7);
				default: res_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			got_r.emit = out_valid;
			got_r.data = out_byte;
			got_r.hit = found;
			got_r.hit_ofs = match_offset;
			got_r.dry = drained;
			n_results++;
			if (pending_results.size() == 0) begin
				flag_mismatch("result with no pending transaction, out_byte", 64'(out_byte), 64'd0);
			end else begin
				want_r = pending_results.pop_front();
				if (got_r.emit !== want_r.emit)
					flag_mismatch("out_valid", 64'(got_r.emit), 64'(want_r.emit));
				if (got_r.data !== want_r.data)
					flag_mismatch("out_byte", 64'(got_r.data), 64'(want_r.data));
				if (got_r.hit !== want_r.hit)
					flag_mismatch("found", 64'(got_r.hit), 64'(want_r.hit));
				if (got_r.hit_ofs !== want_r.hit_ofs)
					flag_mismatch("match_offset", 64'(got_r.hit_ofs), 64'(want_r.hit_ofs));
				if (got_r.dry !== want_r.dry)
					flag_mismatch("drained", 64'(got_r.dry), 64'(want_r.dry));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_LOAD;
		pattern_word = '0;
		dump_byte = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (pat_mem[i]) pat_mem[i] = '0;
		load_ptr = 0;
		stream_pos = '0;
		hit_seen = 1'b0;
		hit_pos = '0;
		words_cfg = '0;
		n_errors = 0;
		n_items = 0;
		n_results = 0;
		n_hits = 0;
		n_dry = 0;
		n_cfg = 0;
		n_eps = 0;
		burst_left = 0;
		long_hold = 1'b0;

		dir_tab = '{
			dir_row(CMD_DRAIN,   '1,                    8'hFF, 1'b1, 1'b0, 8'h00, 1'b1),
			dir_row(CMD_DUMP,    '1,                    8'h00, 1'b1, 1'b1, 8'h00, 1'b0),
			dir_row(CMD_DUMP,    64'd0,                 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0),
			dir_row(CMD_DUMP,    64'h5555_5555_5555_5555, 8'h5A, 1'b1, 1'b1, 8'h5A, 1'b0),
			dir_row(CMD_DUMP,    64'hAAAA_AAAA_AAAA_AAAA, 8'hA5, 1'b0, 1'b0, 8'h00, 1'b0),
			dir_row(CMD_LOAD,    64'd0,                 8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
			dir_row(CMD_LOAD,    '1,                    8'hFF, 1'b1, 1'b0, 8'h00, 1'b0),
			dir_row(CMD_LOAD,    64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
			dir_row(CMD_LOAD,    64'h8000_0000_0000_0001, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0),
			dir_row(CMD_DRAIN,   64'd0,                 8'h00, 1'b1, 1'b0, 8'h00, 1'b1),
			dir_row(CMD_RESTART, '1,                    8'hFF, 1'b1, 1'b0, 8'h00, 1'b0),
			dir_row(CMD_LOAD,    64'hFEDC_BA98_7654_3210, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
			dir_row(CMD_DUMP,    64'd0,                 8'h80, 1'b1, 1'b1, 8'h80, 1'b0),
			dir_row(CMD_DUMP,    '1,                    8'h01, 1'b1, 1'b1, 8'h01, 1'b0),
			dir_row(CMD_RESTART, 64'd0,                 8'h00, 1'b1, 1'b0, 8'h00, 1'b0),
			dir_row(CMD_DRAIN,   '1,                    8'hFF, 1'b1, 1'b0, 8'h00, 1'b1)
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_txn(dir_tab[i].c, dir_tab[i].w, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].r);

		// Fill the whole pattern store once, plus loads that find it full.
		repeat (MAX_WORDS + 2) load_word(pick_word());

		while (n_items < ITEMS_TARGET) scrub_episode(n_eps);

		wait_idle(END_SLACK);
		$display("Covered %0d transactions and %0d results in %0d scan phases, %0d length writes",
			n_items, n_results, n_eps, n_cfg);
		$display("Scrubbed %0d pattern hits and saw %0d drains of an empty window", n_hits, n_dry);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pfsu_pkg.sv
hdl/pfsu_ctrl.sv
hdl/pfsu_datapath.sv
hdl/pattern_find_and_scrub_unit.sv
dv/pattern_find_and_scrub_unit_tb.sv
